// File: hw/rtl/fys_pkg.sv
package fys_pkg;

    // fixed field widths
    localparam int RAND_W  = 31;
    localparam int FIELD_W = 6;
    localparam int CFG_W   = 7;

    // deck size after reset
    localparam int DECK_RST = 52;

    // one remainder bit per dividend bit
    localparam int DIV_STEPS = RAND_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic [RAND_W-1:0]  t_rand_word;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [CFG_W-1:0]   t_cfg_word;

endpackage

// File: hw/rtl/fys_ifs.sv
interface fys_rand_if;
    logic                valid;
    logic                ready;
    fys_pkg::t_rand_word random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

interface fys_res_if;
    logic            valid;
    logic            ready;
    fys_pkg::t_field position;
    fys_pkg::t_field entry;
    logic            last;

    modport source (output valid, output position, output entry, output last, input ready);
    modport sink   (input valid, input position, input entry, input last, output ready);
endinterface

interface fys_cfg_if;
    logic               valid;
    logic               ready;
    fys_pkg::t_cfg_word deck_size;

    modport source (output valid, output deck_size, input ready);
    modport sink   (input valid, input deck_size, output ready);
endinterface

// File: hw/rtl/fys_ram.sv
module fys_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fys_mod.sv
// restoring remainder, one dividend bit per cycle
module fys_mod #(
    parameter int REM_W = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fys_pkg::t_rand_word i_dividend,
    input  logic [REM_W:0]      i_divisor,
    output logic                o_done,
    output logic [REM_W-1:0]    o_rem
);

    logic                         r_busy;
    logic                         r_done;
    logic [fys_pkg::DIV_CNT_W-1:0] r_cnt;
    fys_pkg::t_rand_word          r_dvd;
    logic [REM_W-1:0]             r_rem;
    logic [REM_W:0]               w_shift;
    logic [REM_W-1:0]             n_rem;

    always_comb begin
        w_shift = {r_rem, r_dvd[fys_pkg::RAND_W-1]};
        if (w_shift >= i_divisor) begin
            n_rem = REM_W'(w_shift - i_divisor);
        end else begin
            n_rem = REM_W'(w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == fys_pkg::DIV_CNT_W'(fys_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[fys_pkg::RAND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/fisher_yates_shuffle_engine.sv
// channel   dir  modport        payload                       request meaning
// i_rand    in   sink           random_word[30:0]             one swap step
// o_res     out  source         position[5:0] entry[5:0] last one store entry
// i_cfg     in   sink           deck_size[6:0]                set size, restart round
//
// one swap step: accept, then the bit-serial remainder unit (31 shifts and
// its done flag), then the states S_RD_J, S_WR_I and S_WR_J on the store,
// which has one write port and one read port
// a round end emits n results, each through S_EM_RD, S_EM_LD and S_EM_WAIT, which waits out any output stall
// reset (synchronous, active low) leaves deck size 52 and the identity order
// the store needs no clearing pass: per-entry valid bits give the identity
// i_rand and i_cfg are not ready while a step or the emit sequence is under way
// a waiting size write holds off i_rand in the idle state
module fisher_yates_shuffle_engine #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fys_rand_if.sink  i_rand,
    fys_res_if.source o_res,
    fys_cfg_if.sink   i_cfg
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int NW    = IDX_W + 1;
    localparam int DECK_RST_SAT =
        (fys_pkg::DECK_RST > MAX_ENTRIES) ? MAX_ENTRIES : fys_pkg::DECK_RST;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD_J,
        S_WR_I,
        S_WR_J,
        S_EM_RD,
        S_EM_LD,
        S_EM_WAIT
    } t_state;

    t_state                 r_state;
    logic [NW-1:0]          r_n;          // effective deck size
    logic [IDX_W-1:0]       r_step;       // current swap index i
    logic [IDX_W-1:0]       r_j;
    logic [IDX_W-1:0]       r_vi;         // entry read from position i
    logic [IDX_W-1:0]       r_k;          // emit position
    logic [MAX_ENTRIES-1:0] r_vld;        // entry written since restart
    logic [IDX_W-1:0]       r_rd_addr;
    logic                   r_out_valid;
    fys_pkg::t_field        r_out_pos;
    fys_pkg::t_field        r_out_entry;
    logic                   r_out_last;

    logic                   w_accept;
    logic                   w_cfg_wr;
    logic                   w_div_done;
    logic [IDX_W-1:0]       w_rem;
    logic [NW-1:0]          w_divisor;
    logic [NW-1:0]          n_n;
    logic [IDX_W-1:0]       w_rd_addr;
    logic [IDX_W-1:0]       w_rdata;
    logic [IDX_W-1:0]       w_rdval;      // store value with identity fallback
    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [IDX_W-1:0]       w_wdata;
    logic                   w_step_last;
    logic                   w_emit_last;

    assign w_accept  = i_rand.valid && i_rand.ready;
    assign w_cfg_wr  = i_cfg.valid && i_cfg.ready;
    assign w_divisor = {1'b0, r_step} + 1'b1;

    // saturate the written size to 1..MAX_ENTRIES
    always_comb begin
        if (i_cfg.deck_size == '0) begin
            n_n = NW'(1);
        end else if (i_cfg.deck_size > fys_pkg::CFG_W'(MAX_ENTRIES)) begin
            n_n = NW'(MAX_ENTRIES);
        end else begin
            n_n = NW'(i_cfg.deck_size);
        end
    end

    assign w_step_last = (w_divisor == r_n);
    assign w_emit_last = (({1'b0, r_k} + 1'b1) == r_n);

    // store port control
    always_comb begin
        case (r_state)
            S_RD_J:  w_rd_addr = r_j;
            S_EM_RD: w_rd_addr = r_k;
            default: w_rd_addr = r_step;
        endcase
        w_we    = 1'b0;
        w_waddr = r_step;
        w_wdata = w_rdval;
        case (r_state)
            S_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_step;
                w_wdata = w_rdval;
            end
            S_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_vi;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // an entry never written since restart still holds its own index
    assign w_rdval = r_vld[r_rd_addr] ? w_rdata : r_rd_addr;

    fys_mod #(
        .REM_W (IDX_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_rand.random_word),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    fys_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_rd_addr <= w_rd_addr;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= NW'(DECK_RST_SAT);
            r_step      <= '0;
            r_k         <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cfg_wr) begin
                        // any size write restarts the round
                        r_n    <= n_n;
                        r_step <= '0;
                        r_vld  <= '0;
                    end else if (w_accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_j     <= w_rem;
                        r_vi    <= w_rdval;
                        r_state <= S_RD_J;
                    end
                end
                S_RD_J: begin
                    r_state <= S_WR_I;
                end
                S_WR_I: begin
                    r_state <= S_WR_J;
                end
                S_WR_J: begin
                    if (w_step_last) begin
                        r_k     <= '0;
                        r_state <= S_EM_RD;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EM_RD: begin
                    r_state <= S_EM_LD;
                end
                S_EM_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_pos   <= fys_pkg::FIELD_W'(r_k);
                    r_out_entry <= fys_pkg::FIELD_W'(w_rdval);
                    r_out_last  <= w_emit_last;
                    r_state     <= S_EM_WAIT;
                end
                S_EM_WAIT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            // round done: back to identity
                            r_step  <= '0;
                            r_vld   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // size writes only land between steps, and win over a swap request
    assign i_rand.ready   = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.position = r_out_pos;
    assign o_res.entry    = r_out_entry;
    assign o_res.last     = r_out_last;

    // no new step while a result is pending
    a_ready_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rand.ready |-> !o_res.valid)
        else $error("input ready while a result is pending");

    // remainder unit finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("remainder done outside divide state");

    // last flag marks exactly the final position of the round
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (({1'b0, r_k} + 1'b1) == r_n))
        else $error("last flag on wrong position");

    // swaps never touch entries beyond the deck
    a_wr_in_deck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ({1'b0, w_waddr} < r_n))
        else $error("store write beyond deck size");

endmodule
